[src/dsf_pkg.sv]
// Shared types and constants for the decimal scientific formatter.
`default_nettype none

package dsf_pkg;

    localparam int SIG_W         = 57;
    localparam int EXP_W         = 10;
    localparam int CHAR_W        = 7;
    localparam int DIG_SLOTS     = 17;
    localparam int LEN_W         = 5;
    localparam int SINGLE_DIGITS = 9;
    localparam int BITS_PER_STEP = 3;
    localparam int CONV_STEPS    = SIG_W / BITS_PER_STEP;
    localparam int STEP_W        = 5;
    localparam int MAG_W         = 10;
    localparam int ADJ_W         = 11;

    localparam logic [SIG_W-1:0] SINGLE_LIMIT = 57'd999999999;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_E     = 7'h45;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    typedef struct packed {
        logic [4*DIG_SLOTS-1:0] digits;
        logic [LEN_W-1:0]       len;
        logic                   neg;
        logic [11:0]            edig;
        logic [1:0]             elen;
    } entry_t;

    // 10**n - 1, elaboration only
    function automatic logic [SIG_W-1:0] pow10_m1(input int n);
        logic [SIG_W-1:0] p;
        p = 57'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 57'd10;
        end
        return p - 57'd1;
    endfunction

endpackage

`default_nettype wire

[src/dsf_front.sv]
// Front end: accepts words, converts the significand to BCD, prepares exponent digits.
`default_nettype none

module dsf_front #(
    parameter int MAX_DIGITS = 17
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       double_mode,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [dsf_pkg::SIG_W-1:0]  s_significand,
    input  wire logic [dsf_pkg::EXP_W-1:0]  s_exponent,
    output logic                            q_valid,
    input  wire logic                       q_ready,
    output dsf_pkg::entry_t                 q_data
);
    import dsf_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam logic [SIG_W-1:0] DOUBLE_LIMIT = pow10_m1(MAX_DIGITS);

    typedef enum logic [2:0] {F_IDLE, F_CONV, F_LEN, F_EXP, F_DIG, F_PUSH} fstate_t;

    fstate_t            state_reg;
    logic [SIG_W-1:0]   bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [3:0]         hund_reg;
    logic [6:0]         rem_reg;

    logic [SIG_W-1:0]   limit;
    logic               sat;
    logic [BCD_W-1:0]   nines;
    logic [BCD_W-1:0]   bcd_next;
    logic [SIG_W-1:0]   bin_next;
    logic [LEN_W-1:0]   len_next;
    logic [ADJ_W-1:0]   adj;
    logic [ADJ_W-1:0]   adj_abs;
    logic [MAG_W-1:0]   mag_next;
    logic [15:0]        hprod;
    logic [3:0]         hund_next;
    logic [6:0]         rem_next;
    logic [13:0]        tprod;
    logic [3:0]         tens;
    logic [3:0]         ones;

    assign limit = double_mode ? DOUBLE_LIMIT : SINGLE_LIMIT;
    assign sat   = s_significand > limit;

    for (genvar gi = 0; gi < MAX_DIGITS; gi++) begin : g_nines
        assign nines[4*gi +: 4] = (double_mode || gi < SINGLE_DIGITS) ? 4'd9 : 4'd0;
    end

    // three double-dabble bits per cycle
    always_comb begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (bcd_next[4*i +: 4] >= 4'd5) begin
                    bcd_next[4*i +: 4] = bcd_next[4*i +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[SIG_W-1]};
            bin_next = {bin_next[SIG_W-2:0], 1'b0};
        end
    end

    always_comb begin
        len_next = LEN_W'(1);
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                len_next = LEN_W'(i + 1);
            end
        end
    end

    always_comb begin
        adj      = {exp_reg[EXP_W-1], exp_reg} + {{(ADJ_W-LEN_W){1'b0}}, len_reg}
                   - ADJ_W'(1);
        adj_abs  = adj[ADJ_W-1] ? (~adj + ADJ_W'(1)) : adj;
        mag_next = adj_abs[MAG_W-1:0];
        if (!double_mode && adj_abs > ADJ_W'(99)) begin
            mag_next = MAG_W'(99);
        end else if (adj_abs > ADJ_W'(999)) begin
            mag_next = MAG_W'(999);
        end
    end

    // hundreds by reciprocal (exact below 1000)
    assign hprod     = {6'd0, mag_reg} * 16'd41;
    assign hund_next = hprod[15:12];
    assign rem_next  = 7'(mag_reg - (MAG_W'(hund_next) * MAG_W'(100)));

    // tens by reciprocal (exact below 100)
    assign tprod = {7'd0, rem_reg} * 14'd103;
    assign tens  = tprod[13:10];
    assign ones  = 4'(rem_reg - (7'(tens) * 7'd10));

    assign s_ready = (state_reg == F_IDLE);
    assign q_valid = (state_reg == F_PUSH);

    always_comb begin
        q_data        = '0;
        q_data.digits = (4*DIG_SLOTS)'(bcd_reg);
        q_data.len    = len_reg;
        q_data.neg    = neg_reg;
        q_data.edig   = {hund_reg, tens, ones};
        if (hund_reg != 4'd0) begin
            q_data.elen = 2'd3;
        end else if (rem_reg >= 7'd10) begin
            q_data.elen = 2'd2;
        end else begin
            q_data.elen = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        exp_reg <= s_exponent;
                        cnt_reg <= '0;
                        if (sat) begin
                            bcd_reg   <= nines;
                            state_reg <= F_LEN;
                        end else begin
                            bin_reg   <= s_significand;
                            bcd_reg   <= '0;
                            state_reg <= F_CONV;
                        end
                    end
                end
                F_CONV: begin
                    bcd_reg <= bcd_next;
                    bin_reg <= bin_next;
                    cnt_reg <= cnt_reg + STEP_W'(1);
                    if (cnt_reg == STEP_W'(CONV_STEPS - 1)) begin
                        state_reg <= F_LEN;
                    end
                end
                F_LEN: begin
                    len_reg   <= len_next;
                    state_reg <= F_EXP;
                end
                F_EXP: begin
                    neg_reg   <= adj[ADJ_W-1];
                    mag_reg   <= mag_next;
                    state_reg <= F_DIG;
                end
                F_DIG: begin
                    hund_reg  <= hund_next;
                    rem_reg   <= rem_next;
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (q_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/dsf_fifo.sv]
// Short queue of prepared numbers between front and back end.
`default_nettype none

module dsf_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire dsf_pkg::entry_t wr_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output dsf_pkg::entry_t      rd_data
);
    import dsf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/dsf_back.sv]
// Back end: walks a prepared number and emits its characters one per word.
`default_nettype none

module dsf_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    output logic                             q_ready,
    input  wire dsf_pkg::entry_t             q_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [dsf_pkg::CHAR_W-1:0]       m_character,
    output logic                             m_last
);
    import dsf_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_LEAD, B_DOT, B_FRAC, B_E, B_NEG, B_EXP} bstate_t;

    bstate_t            state_reg;
    entry_t             ent_reg;
    logic [LEN_W-1:0]   idx_reg;
    logic [1:0]         eidx_reg;
    logic               m_valid_reg;
    logic [CHAR_W-1:0]  m_char_reg;
    logic               m_last_reg;

    logic               adv;
    logic [3:0]         sig_dig;
    logic [3:0]         exp_dig;

    assign adv     = !m_valid_reg || m_ready;
    assign q_ready = (state_reg == B_IDLE);
    assign sig_dig = ent_reg.digits[4*idx_reg +: 4];
    assign exp_dig = ent_reg.edig[4*eidx_reg +: 4];

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            if (state_reg == B_IDLE) begin
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
                if (q_valid) begin
                    ent_reg   <= q_data;
                    idx_reg   <= q_data.len - LEN_W'(1);
                    state_reg <= B_LEAD;
                end
            end else if (adv) begin
                m_valid_reg <= 1'b1;
                m_last_reg  <= 1'b0;
                case (state_reg)
                    B_LEAD: begin
                        m_char_reg <= CH_ZERO + {3'b000, sig_dig};
                        idx_reg    <= idx_reg - LEN_W'(1);
                        state_reg  <= (ent_reg.len > LEN_W'(1)) ? B_DOT : B_E;
                    end
                    B_DOT: begin
                        m_char_reg <= CH_DOT;
                        state_reg  <= B_FRAC;
                    end
                    B_FRAC: begin
                        m_char_reg <= CH_ZERO + {3'b000, sig_dig};
                        idx_reg    <= idx_reg - LEN_W'(1);
                        if (idx_reg == '0) begin
                            state_reg <= B_E;
                        end
                    end
                    B_E: begin
                        m_char_reg <= CH_E;
                        eidx_reg   <= ent_reg.elen - 2'd1;
                        state_reg  <= ent_reg.neg ? B_NEG : B_EXP;
                    end
                    B_NEG: begin
                        m_char_reg <= CH_MINUS;
                        state_reg  <= B_EXP;
                    end
                    B_EXP: begin
                        m_char_reg <= CH_ZERO + {3'b000, exp_dig};
                        eidx_reg   <= eidx_reg - 2'd1;
                        if (eidx_reg == 2'd0) begin
                            m_last_reg <= 1'b1;
                            state_reg  <= B_IDLE;
                        end
                    end
                    default: begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= B_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[src/decimal_scientific_formatter_unit.sv]
// Top level: decimal scientific formatter, front end, queue and back end.
// An accepted word passes the BCD conversion at 3 bits a cycle (skipped when the significand
//   saturates) and the length, exponent and digit states before its first character, and
//   waits longer while the back end still emits earlier numbers.
// The front end takes no new number until the last one is in the queue; the back
//   end emits one character a cycle while m_ready allows, plus an idle state per number.
// Reset: synchronous active-low aresetn empties queue and output; double_mode resets to 1.
`default_nettype none

module decimal_scientific_formatter_unit #(
    parameter int MAX_DIGITS  = 17,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [dsf_pkg::SIG_W-1:0]  s_significand,
    input  wire logic [dsf_pkg::EXP_W-1:0]  s_exponent,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [dsf_pkg::CHAR_W-1:0]      m_character,
    output logic                            m_last
);
    import dsf_pkg::*;

    logic   double_mode_reg;
    logic   fq_valid;
    logic   fq_ready;
    entry_t fq_data;
    logic   qb_valid;
    logic   qb_ready;
    entry_t qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            double_mode_reg <= cfg_wr_data;
        end
    end

    dsf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .double_mode   (double_mode_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_significand (s_significand),
        .s_exponent    (s_exponent),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    dsf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    dsf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

[src/dsf_checker.sv]
// Port-level assertions for the formatter output, bound to the top level.
`default_nettype none

module dsf_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [dsf_pkg::CHAR_W-1:0] m_character,
    input wire logic                       m_last
);
    import dsf_pkg::*;

    logic is_digit;
    assign is_digit = (m_character >= CH_ZERO) && (m_character <= CH_ZERO + 7'd9);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("output word changed while stalled");

    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> is_digit || m_character == CH_DOT || m_character == CH_E
                    || m_character == CH_MINUS)
        else $error("character outside the formatter alphabet");

    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> is_digit)
        else $error("number text ends on a non-digit");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind decimal_scientific_formatter_unit dsf_checker u_dsf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last      (m_last)
);

`default_nettype wire

[tb/decimal_scientific_formatter_unit_tb.sv]
// Self-checking testbench: directed and random numbers formatted as scientific text.
module decimal_scientific_formatter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int WORDS_PER_PHASE = 25;
    localparam int TAIL_CYCLES     = 40;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_word_t;

    typedef struct {
        bit               mode;
        logic [SIG_W-1:0] sig;
        logic [EXP_W-1:0] exp;
        string            text;
    } directed_row_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic              cfg_wr_data   = 1'b1;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [SIG_W-1:0]  s_significand = '0;
    logic [EXP_W-1:0]  s_exponent    = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [CHAR_W-1:0] m_character;
    logic              m_last;

    char_word_t    pending_chars[$];
    directed_row_t directed_rows[$];
    bit            double_mode_q = 1'b1;
    int            errors        = 0;
    int            s_idle_pct    = 0;
    int            m_stall_pct   = 0;
    int            idle_cycles   = 0;

    decimal_scientific_formatter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_significand (s_significand),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_character   (m_character),
        .m_last        (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void push_char(logic [CHAR_W-1:0] code);
        pending_chars.push_back('{code, 1'b0});
    endfunction

    function automatic void push_text(string text);
        for (int i = 0; i < text.len(); i++) begin
            push_char(CHAR_W'(text[i]));
        end
        pending_chars[pending_chars.size()-1].last = 1'b1;
    endfunction

    // expected characters of one number, appended to pending_chars
    function automatic void format_scientific(logic [SIG_W-1:0] sig, logic [EXP_W-1:0] exp,
                                              bit dbl);
        longint unsigned value;
        longint unsigned bound;
        logic [3:0]      digit_buf[17];
        int              max_len;
        int              len;
        int              adj;
        int              mag;
        max_len = dbl ? 17 : SINGLE_DIGITS;
        bound = 1;
        repeat (max_len) bound = bound * 10;
        value = sig;
        if (value > bound - 1) begin
            value = bound - 1;
        end
        len = 0;
        do begin
            digit_buf[len] = 4'(value % 10);
            value = value / 10;
            len++;
        end while (value != 0);
        push_char(CH_ZERO + CHAR_W'(digit_buf[len-1]));
        if (len > 1) begin
            push_char(CH_DOT);
        end
        for (int i = len - 2; i >= 0; i--) begin
            push_char(CH_ZERO + CHAR_W'(digit_buf[i]));
        end
        push_char(CH_E);
        adj = int'($signed(exp)) + len - 1;
        if (adj < 0) begin
            push_char(CH_MINUS);
            mag = -adj;
        end else begin
            mag = adj;
        end
        if (!dbl && mag > 99) begin
            mag = 99;
        end
        if (mag > 999) begin
            mag = 999;
        end
        if (mag >= 100) begin
            push_char(CH_ZERO + CHAR_W'(mag / 100));
        end
        if (mag >= 10) begin
            push_char(CH_ZERO + CHAR_W'((mag / 10) % 10));
        end
        push_char(CH_ZERO + CHAR_W'(mag % 10));
        pending_chars[pending_chars.size()-1].last = 1'b1;
    endfunction

    function automatic logic [SIG_W-1:0] rand_significand(bit dbl);
        logic [63:0]     raw;
        longint unsigned low;
        int              digits;
        int              pick;
        raw = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 10) begin
            return raw[SIG_W-1:0];
        end
        if (pick < 15) begin
            return SIG_W'($urandom_range(9));
        end
        digits = $urandom_range(dbl ? 17 : 10, 1);
        low = 1;
        repeat (digits - 1) low = low * 10;
        return SIG_W'(low + raw % (9 * low));
    endfunction

    function automatic logic [EXP_W-1:0] rand_exponent();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            return EXP_W'($urandom);
        end
        if (pick < 20) begin
            case ($urandom_range(3))
                0: return EXP_W'(-340);
                1: return EXP_W'(308);
                2: return EXP_W'(-512);
                default: return EXP_W'(511);
            endcase
        end
        return EXP_W'(int'($urandom_range(648)) - 340);
    endfunction

    task automatic send_word(logic [SIG_W-1:0] sig, logic [EXP_W-1:0] exp, string text);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_significand <= sig;
        s_exponent    <= exp;
        do @(posedge aclk); while (!s_ready);
        if (text.len() == 0) begin
            format_scientific(sig, exp, double_mode_q);
        end else begin
            push_text(text);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic set_mode(bit mode);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        double_mode_q = mode;
    endtask

    // receiver: random stalls, compare each word with the oldest expectation
    always @(posedge aclk) begin
        char_word_t want;
        m_ready <= ($urandom_range(99) >= m_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected word: char %h last %b", m_character, m_last);
                end
            end else begin
                want = pending_chars.pop_front();
                if (m_character !== want.code || m_last !== want.last) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("mismatch: expected char %h last %b, got char %h last %b",
                                 want.code, want.last, m_character, m_last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        directed_rows.push_back('{1'b1, SIG_W'(0), EXP_W'(0), "0E0"});
        directed_rows.push_back('{1'b1, SIG_W'(1), EXP_W'(0), "1E0"});
        directed_rows.push_back('{1'b1, SIG_W'(10), EXP_W'(0), "1.0E1"});
        directed_rows.push_back('{1'b1, SIG_W'(12), EXP_W'(-1), "1.2E0"});
        directed_rows.push_back('{1'b1, SIG_W'(123), EXP_W'(-4), "1.23E-2"});
        directed_rows.push_back('{1'b1, 57'd99999999999999999, EXP_W'(308),
                                  "9.9999999999999999E324"});
        directed_rows.push_back('{1'b1, SIG_W'(1), EXP_W'(-340), "1E-340"});
        // significand too long: saturates to all nines
        directed_rows.push_back('{1'b1, {SIG_W{1'b1}}, EXP_W'(-340),
                                  "9.9999999999999999E-324"});
        directed_rows.push_back('{1'b1, 57'd100000000000000000, EXP_W'(0),
                                  "9.9999999999999999E16"});
        directed_rows.push_back('{1'b1, SIG_W'(1), EXP_W'(511), "1E511"});
        directed_rows.push_back('{1'b1, SIG_W'(7), EXP_W'(-512), "7E-512"});
        directed_rows.push_back('{1'b1, SIG_W'(0), EXP_W'(-1), "0E-1"});
        directed_rows.push_back('{1'b1, 57'd123456789012345, EXP_W'(7), ""});
        directed_rows.push_back('{1'b1, 57'd4503599627370496, EXP_W'(-100), ""});
        directed_rows.push_back('{1'b0, SIG_W'(0), EXP_W'(-5), "0E-5"});
        // exponent too long in single mode: clamps to 99, sign kept
        directed_rows.push_back('{1'b0, SIG_W'(999999999), EXP_W'(99), "9.99999999E99"});
        directed_rows.push_back('{1'b0, SIG_W'(1000000000), EXP_W'(0), "9.99999999E8"});
        directed_rows.push_back('{1'b0, SIG_W'(1), EXP_W'(-512), "1E-99"});
        directed_rows.push_back('{1'b0, SIG_W'(1), EXP_W'(511), "1E99"});
        directed_rows.push_back('{1'b0, SIG_W'(3), EXP_W'(9), "3E9"});
        directed_rows.push_back('{1'b0, SIG_W'(12345678), EXP_W'(-45), "1.2345678E-38"});
        directed_rows.push_back('{1'b0, {SIG_W{1'b1}}, EXP_W'(-100), ""});
        directed_rows.push_back('{1'b0, SIG_W'(16777216), EXP_W'(30), ""});
        directed_rows.push_back('{1'b1, SIG_W'(5), EXP_W'(0), "5E0"});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != double_mode_q) begin
                set_mode(directed_rows[i].mode);
            end
            send_word(directed_rows[i].sig, directed_rows[i].exp, directed_rows[i].text);
        end

        for (int phase = 0; phase < 8; phase++) begin
            set_mode(phase % 2 == 0);
            case (phase / 2)
                0: begin s_idle_pct = 0;  m_stall_pct = 0;  end
                1: begin s_idle_pct = 48; m_stall_pct = 0;  end
                2: begin s_idle_pct = 0;  m_stall_pct = 48; end
                default: begin s_idle_pct = 11; m_stall_pct = 11; end
            endcase
            repeat (WORDS_PER_PHASE) begin
                send_word(rand_significand(double_mode_q), rand_exponent(), "");
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_chars.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
src/dsf_pkg.sv
src/dsf_front.sv
src/dsf_fifo.sv
src/dsf_back.sv
src/decimal_scientific_formatter_unit.sv
src/dsf_checker.sv
tb/decimal_scientific_formatter_unit_tb.sv
